@@ sv/clnib_pkg.sv @@
`timescale 1ns / 1ps

package clnib_pkg;

    typedef enum logic [2:0] {
        KIND_TICK  = 3'd0,
        KIND_INIT  = 3'd1,
        KIND_CMD   = 3'd2,
        KIND_DATA  = 3'd3,
        KIND_POS   = 3'd4,
        KIND_CLEAR = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        CFG_POWER_UP = 2'd0,
        CFG_PULSE    = 2'd1,
        CFG_POST     = 2'd2,
        CFG_CLEAR    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_POWER  = 2'd1,
        PH_STROBE = 2'd2,
        PH_WAIT   = 2'd3
    } phase_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] POWER_UP_RST = 8'd40;
    localparam logic [3:0] PULSE_RST    = 4'd1;
    localparam logic [3:0] POST_RST     = 4'd1;
    localparam logic [3:0] CLEAR_RST    = 4'd2;

    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [6:0] ROW1_BASE    = 7'h40;

    typedef struct packed {
        logic [7:0] power_up_ticks;
        logic [3:0] enable_pulse_ticks;
        logic [3:0] post_write_ticks;
        logic [3:0] clear_wait_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_value;
        logic [5:0] column;
        logic       row;
    } item_t;

    typedef struct packed {
        logic       reg_select;
        logic       enable;
        logic [3:0] data_nibble;
        logic       busy_res;
        logic       rejected;
    } res_t;

endpackage

@@ sv/clnib_req_if.sv @@
`timescale 1ns / 1ps

interface clnib_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] byte_value;
    logic [5:0] column;
    logic       row;

    modport source (output valid, kind, byte_value, column, row, input ready);
    modport sink (input valid, kind, byte_value, column, row, output ready);
endinterface

@@ sv/clnib_res_if.sv @@
`timescale 1ns / 1ps

interface clnib_res_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic       enable;
    logic [3:0] data_nibble;
    logic       busy_res;
    logic       rejected;

    modport source (output valid, reg_select, enable, data_nibble, busy_res, rejected,
                    input ready);
    modport sink (input valid, reg_select, enable, data_nibble, busy_res, rejected,
                  output ready);
endinterface

@@ sv/clnib_cfg_regs.sv @@
`timescale 1ns / 1ps

module clnib_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [clnib_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [clnib_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output clnib_pkg::cfg_t                      cfg
);
    import clnib_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_POWER_UP: cfg_next.power_up_ticks     = cfg_wdata;
                CFG_PULSE:    cfg_next.enable_pulse_ticks = cfg_wdata[3:0];
                CFG_POST:     cfg_next.post_write_ticks   = cfg_wdata[3:0];
                CFG_CLEAR:    cfg_next.clear_wait_ticks   = cfg_wdata[3:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_up_ticks     <= POWER_UP_RST;
            cfg_reg.enable_pulse_ticks <= PULSE_RST;
            cfg_reg.post_write_ticks   <= POST_RST;
            cfg_reg.clear_wait_ticks   <= CLEAR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/clnib_engine.sv @@
`timescale 1ns / 1ps

module clnib_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  clnib_pkg::item_t item,
    input  clnib_pkg::cfg_t  cfg,
    output clnib_pkg::res_t  result
);
    import clnib_pkg::*;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] wait_count;
        logic [7:0] shift_byte;
        logic       select_level;
        logic       low_pending;
        logic [3:0] init_step;
        logic [3:0] pins_nibble;
    } state_t;

    state_t st_reg;
    state_t st_next;
    logic   rej;
    logic [3:0] pulse_len;

    function automatic logic [3:0] rom_nib(input logic [1:0] idx);
        return (idx == 2'd3) ? 4'h2 : 4'h3;
    endfunction

    function automatic logic [7:0] rom_hold(input logic [1:0] idx);
        return (idx[1] == 1'b0) ? 8'd5 : 8'd1;
    endfunction

    function automatic logic [7:0] rom_cmd(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h28;
            3'd1:    v = 8'h0C;
            3'd2:    v = 8'h01;
            3'd3:    v = 8'h06;
            3'd4:    v = 8'h02;
            default: v = CMD_CLEAR;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] rom_wait(input logic [2:0] idx);
        return (idx == 3'd4) ? 8'd5 : 8'd1;
    endfunction

    function automatic state_t start_byte(input state_t s, input logic [7:0] v,
                                          input logic rs, input logic [3:0] pulse);
        state_t n;
        n              = s;
        n.shift_byte   = v;
        n.select_level = rs;
        n.pins_nibble  = v[7:4];
        n.low_pending  = 1'b1;
        n.phase        = PH_STROBE;
        n.wait_count   = {4'd0, pulse};
        return n;
    endfunction

    function automatic logic [7:0] post_wait(input state_t s, input cfg_t c);
        logic [7:0] w;
        logic [4:0] sum;
        sum = {1'b0, c.post_write_ticks} + {1'b0, c.clear_wait_ticks};
        if (s.init_step inside {[4'd2:4'd5]})
            w = 8'd0;
        else if (s.init_step inside {[4'd6:4'd10]})
            w = rom_wait(3'(s.init_step - 4'd6));
        else if (!s.select_level && s.shift_byte == CMD_CLEAR)
            w = {3'd0, sum};
        else
            w = {4'd0, c.post_write_ticks};
        return w;
    endfunction

    // step through the init ROM: power wait, four raw nibbles, six commands
    function automatic state_t advance(input state_t s, input logic [3:0] pulse);
        state_t n;
        logic [3:0] step;
        n = s;
        if (s.init_step inside {[4'd1:4'd10]})
        begin
            step        = s.init_step + 4'd1;
            n.init_step = step;
            if (step inside {[4'd2:4'd5]})
            begin
                n.select_level = 1'b0;
                n.pins_nibble  = rom_nib(2'(step - 4'd2));
                n.low_pending  = 1'b0;
                n.phase        = PH_STROBE;
                n.wait_count   = rom_hold(2'(step - 4'd2));
            end
            else
            begin
                n = start_byte(n, rom_cmd(3'(step - 4'd6)), 1'b0, pulse);
            end
        end
        else
        begin
            n.init_step = 4'd0;
            n.phase     = PH_IDLE;
        end
        return n;
    endfunction

    function automatic state_t do_tick(input state_t s, input cfg_t c,
                                       input logic [3:0] pulse);
        state_t n;
        logic   done;
        n    = s;
        done = (s.wait_count <= 8'd1);
        case (s.phase)
            PH_POWER:
            begin
                if (done)
                begin
                    n.wait_count = 8'd0;
                    n = advance(n, pulse);
                end
                else
                    n.wait_count = s.wait_count - 8'd1;
            end
            PH_STROBE:
            begin
                if (done)
                begin
                    n.phase      = PH_WAIT;
                    n.wait_count = s.low_pending ? 8'd0 : post_wait(s, c);
                end
                else
                    n.wait_count = s.wait_count - 8'd1;
            end
            PH_WAIT:
            begin
                if (done)
                begin
                    n.wait_count = 8'd0;
                    if (s.low_pending)
                    begin
                        n.pins_nibble = s.shift_byte[3:0];
                        n.low_pending = 1'b0;
                        n.phase       = PH_STROBE;
                        n.wait_count  = {4'd0, pulse};
                    end
                    else
                        n = advance(n, pulse);
                end
                else
                    n.wait_count = s.wait_count - 8'd1;
            end
            default: n.phase = PH_IDLE;
        endcase
        return n;
    endfunction

    assign pulse_len = (cfg.enable_pulse_ticks == 4'd0) ? 4'd1 : cfg.enable_pulse_ticks;

    always_comb
    begin
        st_next = st_reg;
        rej     = 1'b0;
        if (kind_t'(item.kind) == KIND_TICK)
            st_next = do_tick(st_reg, cfg, pulse_len);
        else if (kind_t'(item.kind) inside {[KIND_INIT:KIND_CLEAR]})
        begin
            if (st_reg.phase != PH_IDLE)
                rej = 1'b1;
            else
            begin
                case (kind_t'(item.kind))
                    KIND_INIT:
                    begin
                        st_next.init_step    = 4'd1;
                        st_next.select_level = 1'b0;
                        st_next.low_pending  = 1'b0;
                        st_next.phase        = PH_POWER;
                        st_next.wait_count   = cfg.power_up_ticks;
                    end
                    KIND_CMD:
                        st_next = start_byte(st_reg, item.byte_value, 1'b0, pulse_len);
                    KIND_DATA:
                        st_next = start_byte(st_reg, item.byte_value, 1'b1, pulse_len);
                    KIND_POS:
                        st_next = start_byte(st_reg,
                            CMD_SET_ADDR | {1'b0, (item.row ? ROW1_BASE : 7'd0)
                                                  + {1'b0, item.column}},
                            1'b0, pulse_len);
                    default:
                        st_next = start_byte(st_reg, CMD_CLEAR, 1'b0, pulse_len);
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{phase: PH_IDLE, default: '0};
        end
        else if (fire)
        begin
            st_reg <= st_next;
        end
    end

    assign result.reg_select  = st_next.select_level;
    assign result.enable      = (st_next.phase == PH_STROBE);
    assign result.data_nibble = st_next.pins_nibble;
    assign result.busy_res    = (st_next.phase != PH_IDLE);
    assign result.rejected    = rej;

`ifndef SYNTHESIS
    // init sequencer never runs past the final clear
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.init_step <= 4'd11)
        else $error("init step out of range");

    // a byte's low half is only pending while a byte is in flight
    a_low_busy: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.low_pending |-> (st_reg.phase == PH_STROBE || st_reg.phase == PH_WAIT))
        else $error("low nibble pending while not transferring");

    // a rejected request leaves the state untouched
    a_rej_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && rej) |=> st_reg == $past(st_reg))
        else $error("rejected request changed state");
`endif

endmodule

@@ sv/char_lcd_nibble_interface.sv @@
`timescale 1ns / 1ps

// A word goes input register -> state update -> result register before the result port.
// Throughput: one word per cycle while the result port is not stalled by rsp.ready.
// Each request or tick gives exactly one result word.
// Reset (rst_n, async low): controller idle, pins low, config registers to defaults,
// both pipeline stages empty.
module char_lcd_nibble_interface (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [clnib_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [clnib_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    clnib_req_if.sink                         req,
    clnib_res_if.source                       rsp
);
    import clnib_pkg::*;

    cfg_t  cfg;
    item_t in_item_reg;
    logic  in_valid_reg;
    res_t  out_reg;
    logic  out_valid_reg;
    res_t  result;
    logic  adv;
    logic  fire;

    clnib_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    clnib_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // output slot frees when empty or being taken this cycle
    assign adv       = !out_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && adv;
    assign req.ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (adv)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_item_reg.kind       <= req.kind;
            in_item_reg.byte_value <= req.byte_value;
            in_item_reg.column     <= req.column;
            in_item_reg.row        <= req.row;
        end
        if (fire)
            out_reg <= result;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.reg_select  = out_reg.reg_select;
    assign rsp.enable      = out_reg.enable;
    assign rsp.data_nibble = out_reg.data_nibble;
    assign rsp.busy_res    = out_reg.busy_res;
    assign rsp.rejected    = out_reg.rejected;

`ifndef SYNTHESIS
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> req.ready)
        else $error("input stalled with empty output slot");

    a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed word did not reach output");

    a_en_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.enable) |-> rsp.busy_res)
        else $error("enable high while idle");

    a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.rejected) |-> rsp.busy_res)
        else $error("rejected while idle");
`endif

endmodule

@@ test/lcd_pin_checker.sv @@
`timescale 1ns / 1ps

module lcd_pin_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [clnib_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [clnib_pkg::CFG_DATA_W-1:0] cfg_wdata,
    clnib_req_if                             req,
    clnib_res_if                             rsp,
    output int                               mismatches,
    output int                               pending_words,
    output int                               words_checked,
    output int                               rejects_seen,
    output logic                             lcd_busy
);
    import clnib_pkg::*;

    // init sequence steps
    localparam int STEP_POWER     = 1;
    localparam int STEP_NIB_FIRST = 2;
    localparam int STEP_NIB_LAST  = 5;
    localparam int STEP_CMD_FIRST = 6;
    localparam int STEP_HOME      = 10;
    localparam int STEP_CMD_LAST  = 11;

    localparam logic [3:0] NIB_WAKE        = 4'h3;
    localparam logic [3:0] NIB_4BIT        = 4'h2;
    localparam logic [7:0] WAKE_HOLD_LONG  = 8'd5;
    localparam logic [7:0] WAKE_HOLD_SHORT = 8'd1;
    localparam logic [7:0] CMD_FUNC_SET    = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
    localparam logic [7:0] CMD_HOME        = 8'h02;
    localparam logic [7:0] ROM_CMD_WAIT    = 8'd1;
    localparam logic [7:0] HOME_WAIT       = 8'd5;

    cfg_t       regs;
    phase_t     ph;
    logic [7:0] cnt;
    logic [7:0] shift_val;
    logic       rs_level;
    logic       low_due;
    logic [3:0] init_step;
    logic [3:0] pins;
    res_t       pins_due[$];

    function automatic logic [7:0] hold_ticks();
        return (regs.enable_pulse_ticks == 4'd0) ? 8'd1 : {4'd0, regs.enable_pulse_ticks};
    endfunction

    function automatic logic [7:0] byte_wait_ticks();
        if (init_step >= STEP_NIB_FIRST && init_step <= STEP_NIB_LAST)
            return 8'd0;
        if (init_step >= STEP_CMD_FIRST && init_step <= STEP_HOME)
            return (init_step == STEP_HOME) ? HOME_WAIT : ROM_CMD_WAIT;
        if (!rs_level && shift_val == CMD_CLEAR)
            return {4'd0, regs.post_write_ticks} + {4'd0, regs.clear_wait_ticks};
        return {4'd0, regs.post_write_ticks};
    endfunction

    function automatic logic [7:0] rom_command(input logic [3:0] step);
        case (step)
            4'd6:    return CMD_FUNC_SET;
            4'd7:    return CMD_DISPLAY_ON;
            4'd9:    return CMD_ENTRY_MODE;
            4'd10:   return CMD_HOME;
            default: return CMD_CLEAR;
        endcase
    endfunction

    function automatic void load_byte(input logic [7:0] value, input logic rs);
        shift_val = value;
        rs_level  = rs;
        pins      = value[7:4];
        low_due   = 1'b1;
        ph        = PH_STROBE;
        cnt       = hold_ticks();
    endfunction

    function automatic void launch_step();
        if (init_step >= STEP_NIB_FIRST && init_step <= STEP_NIB_LAST)
        begin
            rs_level = 1'b0;
            pins     = (init_step == STEP_NIB_LAST) ? NIB_4BIT : NIB_WAKE;
            low_due  = 1'b0;
            ph       = PH_STROBE;
            cnt      = (init_step <= STEP_NIB_FIRST + 1) ? WAKE_HOLD_LONG : WAKE_HOLD_SHORT;
        end
        else if (init_step >= STEP_CMD_FIRST && init_step <= STEP_CMD_LAST)
        begin
            load_byte(rom_command(init_step), 1'b0);
        end
        else
        begin
            init_step = 4'd0;
            ph        = PH_IDLE;
        end
    endfunction

    function automatic void advance();
        if (init_step >= STEP_POWER && init_step <= STEP_HOME)
        begin
            init_step = init_step + 4'd1;
            launch_step();
        end
        else
        begin
            init_step = 4'd0;
            ph        = PH_IDLE;
        end
    endfunction

    function automatic void apply_tick();
        case (ph)
            PH_POWER:
                if (cnt <= 8'd1)
                begin
                    cnt = 8'd0;
                    advance();
                end
                else
                    cnt = cnt - 8'd1;
            PH_STROBE:
                if (cnt <= 8'd1)
                begin
                    // enable drops; between halves of a byte it stays low one tick
                    ph  = PH_WAIT;
                    cnt = low_due ? 8'd0 : byte_wait_ticks();
                end
                else
                    cnt = cnt - 8'd1;
            PH_WAIT:
                if (cnt <= 8'd1)
                begin
                    cnt = 8'd0;
                    if (low_due)
                    begin
                        pins    = shift_val[3:0];
                        low_due = 1'b0;
                        ph      = PH_STROBE;
                        cnt     = hold_ticks();
                    end
                    else
                        advance();
                end
                else
                    cnt = cnt - 8'd1;
            default:
                ph = PH_IDLE;
        endcase
    endfunction

    function automatic res_t step_controller(input item_t w);
        res_t       r;
        logic [7:0] addr;
        r.rejected = 1'b0;
        if (w.kind == KIND_TICK)
            apply_tick();
        else if (w.kind <= KIND_CLEAR)
        begin
            if (ph != PH_IDLE)
                r.rejected = 1'b1;
            else
                case (w.kind)
                    KIND_INIT:
                    begin
                        init_step = STEP_POWER;
                        rs_level  = 1'b0;
                        low_due   = 1'b0;
                        ph        = PH_POWER;
                        cnt       = regs.power_up_ticks;
                    end
                    KIND_CMD:  load_byte(w.byte_value, 1'b0);
                    KIND_DATA: load_byte(w.byte_value, 1'b1);
                    KIND_POS:
                    begin
                        addr = w.row ? {1'b0, ROW1_BASE + {1'b0, w.column}} : {2'b00, w.column};
                        load_byte(CMD_SET_ADDR | addr, 1'b0);
                    end
                    default:   load_byte(CMD_CLEAR, 1'b0);
                endcase
        end
        r.reg_select  = rs_level;
        r.enable      = (ph == PH_STROBE);
        r.data_nibble = pins;
        r.busy_res    = (ph != PH_IDLE);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("lcd_chk: word %0d: %s is %0d, expected %0d", words_checked, what,
                 got_v, want_v);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t  got;
        res_t  want;
        item_t w;
        if (!rst_n)
        begin
            regs.power_up_ticks     = POWER_UP_RST;
            regs.enable_pulse_ticks = PULSE_RST;
            regs.post_write_ticks   = POST_RST;
            regs.clear_wait_ticks   = CLEAR_RST;
            ph        = PH_IDLE;
            cnt       = 8'd0;
            shift_val = 8'd0;
            rs_level  = 1'b0;
            low_due   = 1'b0;
            init_step = 4'd0;
            pins      = 4'd0;
            pins_due.delete();
            pending_words <= 0;
            lcd_busy      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                case (cfg_index)
                    CFG_POWER_UP: regs.power_up_ticks     = cfg_wdata;
                    CFG_PULSE:    regs.enable_pulse_ticks = cfg_wdata[3:0];
                    CFG_POST:     regs.post_write_ticks   = cfg_wdata[3:0];
                    default:      regs.clear_wait_ticks   = cfg_wdata[3:0];
                endcase

            // results first so a word never meets an expectation pushed this edge
            if (rsp.valid && rsp.ready)
            begin
                got.reg_select  = rsp.reg_select;
                got.enable      = rsp.enable;
                got.data_nibble = rsp.data_nibble;
                got.busy_res    = rsp.busy_res;
                got.rejected    = rsp.rejected;
                if (pins_due.size() == 0)
                    report_mismatch("result word with nothing outstanding", 1, 0);
                else
                begin
                    want = pins_due.pop_front();
                    if (got.reg_select !== want.reg_select)
                        report_mismatch("reg_select", got.reg_select, want.reg_select);
                    if (got.enable !== want.enable)
                        report_mismatch("enable", got.enable, want.enable);
                    if (got.data_nibble !== want.data_nibble)
                        report_mismatch("data_nibble", got.data_nibble, want.data_nibble);
                    if (got.busy_res !== want.busy_res)
                        report_mismatch("busy_res", got.busy_res, want.busy_res);
                    if (got.rejected !== want.rejected)
                        report_mismatch("rejected", got.rejected, want.rejected);
                    if (want.rejected)
                        rejects_seen++;
                    words_checked++;
                end
            end

            if (req.valid && req.ready)
            begin
                w.kind       = req.kind;
                w.byte_value = req.byte_value;
                w.column     = req.column;
                w.row        = req.row;
                pins_due.push_back(step_controller(w));
            end

            pending_words <= pins_due.size();
            lcd_busy      <= (ph != PH_IDLE);
        end
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import clnib_pkg::*;

    localparam int         STALL_LIMIT  = 4000;
    localparam int         RANDOM_WORDS = 80;
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    send_idle_pct;
    int                    recv_idle_pct;
    int                    words_sent;
    int                    settings_used;
    int                    stall_cycles;
    int                    mismatches;
    int                    pending_words;
    int                    words_checked;
    int                    rejects_seen;
    logic                  lcd_busy;

    clnib_req_if req ();
    clnib_res_if rsp ();

    char_lcd_nibble_interface DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    lcd_pin_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .req           (req),
        .rsp           (rsp),
        .mismatches    (mismatches),
        .pending_words (pending_words),
        .words_checked (words_checked),
        .rejects_seen  (rejects_seen),
        .lcd_busy      (lcd_busy)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic send_word(input logic [2:0] kind, input logic [7:0] value,
                             input logic [5:0] col, input logic r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.kind       <= kind;
        req.byte_value <= value;
        req.column     <= col;
        req.row        <= r;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_tick();
        send_word(KIND_TICK, 8'($urandom_range(255)), 6'($urandom_range(63)),
                  1'($urandom_range(1)));
    endtask

    // hold off until every result is back and the controller has gone idle;
    // lcd_busy lags one accepted word, the drain gives it time to catch up
    task automatic settle();
        do
        begin
            while (lcd_busy)
                send_tick();
            req.valid <= 1'b0;
            @(posedge clk);
            while (pending_words != 0)
                @(posedge clk);
        end
        while (lcd_busy);
    endtask

    task automatic program_regs(input logic [7:0] pwr, input logic [7:0] pulse,
                                input logic [7:0] post, input logic [7:0] clr);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POWER_UP;
        cfg_wdata <= pwr;
        @(posedge clk);
        cfg_index <= CFG_PULSE;
        cfg_wdata <= pulse;
        @(posedge clk);
        cfg_index <= CFG_POST;
        cfg_wdata <= post;
        @(posedge clk);
        cfg_index <= CFG_CLEAR;
        cfg_wdata <= clr;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // small timings so that inits stay short; upper bits of 4-bit regs are junk
    task automatic random_regs();
        program_regs(8'($urandom_range(0, 6)),
                     8'(($urandom_range(15) << 4) | $urandom_range(0, 3)),
                     8'(($urandom_range(15) << 4) | $urandom_range(0, 3)),
                     8'(($urandom_range(15) << 4) | $urandom_range(0, 4)));
    endtask

    task automatic run_random(input int count);
        int         target;
        int         pick;
        logic [2:0] kind;
        logic [7:0] value;
        target = words_sent + count;
        while (words_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                kind  = ($urandom_range(9) == 0) ? KIND_INIT
                                                 : 3'($urandom_range(KIND_CMD, KIND_CLEAR));
                value = ($urandom_range(7) == 0) ? CMD_CLEAR : 8'($urandom_range(255));
                send_word(kind, value, 6'($urandom_range(63)), 1'($urandom_range(1)));
                // clock the transfer out; a stray request now and then hits it busy
                do
                begin
                    if ($urandom_range(99) < 6)
                        send_word(3'($urandom_range(KIND_INIT, KIND_CLEAR)),
                                  8'($urandom_range(255)), 6'($urandom_range(63)),
                                  1'($urandom_range(1)));
                    else
                        send_tick();
                end
                while (lcd_busy);
            end
            else if (pick < 79)
                settle();
            else
                send_word(3'($urandom_range(7)), 8'($urandom_range(255)),
                          6'($urandom_range(63)), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_POWER_UP;
        cfg_wdata      <= '0;
        req.valid      <= 1'b0;
        req.kind       <= KIND_TICK;
        req.byte_value <= '0;
        req.column     <= '0;
        req.row        <= 1'b0;
        send_idle_pct  = 18;
        recv_idle_pct  = 86;
        words_sent     = 0;
        settings_used  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: one of each request, edge values, busy rejects, unknown kinds
        program_regs(8'd0, 8'd1, 8'd0, 8'd0);
        send_word(KIND_TICK, 8'hA5, 6'h2A, 1'b1);
        send_word(KIND_SPARE_LO, 8'hFF, 6'h3F, 1'b1);
        send_word(KIND_SPARE_HI, 8'h00, 6'h00, 1'b0);
        send_word(KIND_CMD, 8'hFF, 6'h00, 1'b0);
        send_word(KIND_DATA, 8'h5A, 6'h3F, 1'b1);
        settle();
        send_word(KIND_DATA, 8'h00, 6'h15, 1'b0);
        settle();
        send_word(KIND_POS, 8'h00, 6'd63, 1'b0);
        settle();
        send_word(KIND_POS, 8'hFF, 6'd0, 1'b1);
        settle();
        send_word(KIND_POS, 8'h00, 6'd63, 1'b1);
        settle();
        send_word(KIND_CLEAR, 8'h7E, 6'h2A, 1'b0);
        settle();
        send_word(KIND_CMD, CMD_CLEAR, 6'h00, 1'b0);
        settle();
        send_word(KIND_INIT, 8'h00, 6'h00, 1'b0);
        send_word(KIND_CMD, 8'h80, 6'h00, 1'b0);
        settle();
        // zero pulse length acts as one tick, zero waits still last a tick
        program_regs(8'd0, 8'hF0, 8'd0, 8'd0);
        send_word(KIND_DATA, 8'hC3, 6'h00, 1'b1);
        settle();
        send_word(KIND_CLEAR, 8'h00, 6'h00, 1'b0);
        settle();
        random_regs();
        run_random(RANDOM_WORDS);

        send_idle_pct = 86;
        recv_idle_pct = 18;
        // full-scale timings on a data byte and a clear
        program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(KIND_DATA, 8'($urandom_range(255)), 6'h00, 1'b1);
        settle();
        send_word(KIND_CMD, CMD_CLEAR, 6'h00, 1'b0);
        settle();
        random_regs();
        run_random(RANDOM_WORDS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_regs();
        run_random(RANDOM_WORDS);

        settle();
        repeat (10) @(posedge clk);
        $display("tb_top: %0d request/tick words driven, %0d result words checked, %0d rejects",
                 words_sent, words_checked, rejects_seen);
        $display("tb_top: 3 stall profiles, %0d register settings incl. zero and full scale",
                 settings_used);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
